>>> src/record_merge_sort_by_name_assert.svh
// assertion macros used by the checker file
`ifndef RECORD_MERGE_SORT_BY_NAME_ASSERT_SVH
`define RECORD_MERGE_SORT_BY_NAME_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RMSBN_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("record sorter check failed");

// next-cycle implication, checked outside reset
`define RMSBN_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("record sorter check failed");

`endif

>>> src/rmsbn_pkg.sv
// types and constants of the record sorter
package rmsbn_pkg;

   localparam int KEY_BITS = 160;

   typedef struct packed {
      logic [63:0] name_head;
      logic [63:0] name_middle;
      logic [31:0] name_tail;
      logic [1:0]  blood_group;
      logic        available;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] out_name_head;
      logic [63:0] out_name_middle;
      logic [31:0] out_name_tail;
      logic [1:0]  out_blood_group;
      logic        out_available;
      logic        out_last;
      logic        overflowed;
   } rsp_type;

   // one stored record: name key followed by the carried fields
   typedef struct packed {
      logic [KEY_BITS-1:0] name;
      logic [1:0]          blood_group;
      logic                available;
   } rec_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

>>> src/rmsbn_cell.sv
// one cell of the systolic insertion sorter
module rmsbn_cell #(
   parameter int SEQ_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                in_valid,
   input  rmsbn_pkg::rec_type  in_rec,
   input  logic [SEQ_W-1:0]    in_seq,
   output logic                out_valid,
   output rmsbn_pkg::rec_type  out_rec,
   output logic [SEQ_W-1:0]    out_seq,
   input  logic                right_valid,
   input  rmsbn_pkg::rec_type  right_rec,
   input  logic [SEQ_W-1:0]    right_seq,
   output logic                held_valid,
   output rmsbn_pkg::rec_type  held_rec,
   output logic [SEQ_W-1:0]    held_seq
);

   logic               held_valid_ff, held_valid_in;
   rmsbn_pkg::rec_type held_rec_ff, held_rec_in;
   logic [SEQ_W-1:0]   held_seq_ff, held_seq_in;
   logic               out_valid_ff, out_valid_in;
   rmsbn_pkg::rec_type out_rec_ff, out_rec_in;
   logic [SEQ_W-1:0]   out_seq_ff, out_seq_in;
   logic               take_in;

   // arrival number breaks ties, so equal names keep load order
   assign take_in = in_valid &&
      (!held_valid_ff || ({in_rec.name, in_seq} < {held_rec_ff.name, held_seq_ff}));

   always_comb begin
      held_valid_in = held_valid_ff;
      held_rec_in   = held_rec_ff;
      held_seq_in   = held_seq_ff;
      out_valid_in  = 1'b0;
      out_rec_in    = in_rec;
      out_seq_in    = in_seq;
      if (shift) begin
         held_valid_in = right_valid;
         held_rec_in   = right_rec;
         held_seq_in   = right_seq;
      end else if (in_valid) begin
         out_valid_in = held_valid_ff;
         if (take_in) begin
            held_valid_in = 1'b1;
            held_rec_in   = in_rec;
            held_seq_in   = in_seq;
            out_rec_in    = held_rec_ff;
            out_seq_in    = held_seq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      held_rec_ff <= held_rec_in;
      held_seq_ff <= held_seq_in;
      out_rec_ff  <= out_rec_in;
      out_seq_ff  <= out_seq_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_rec    = out_rec_ff;
   assign out_seq    = out_seq_ff;
   assign held_valid = held_valid_ff;
   assign held_rec   = held_rec_ff;
   assign held_seq   = held_seq_ff;

endmodule

>>> src/record_merge_sort_by_name.sv
// top level of the record sorter: load control, cell chain and output side
//
//   channel  ports                       direction  moves
//   request  req_valid req_stall req_data  in       one donor record per transfer
//   response rsp_valid rsp_stall rsp_data  out      one sorted record per transfer
//
// loading takes one record per cycle; each record ripples one cell per cycle
// the record marked last is followed by a settle phase set by the length of the
// cell chain, then one sorted record per cycle is offered while rsp_stall is low
// req_stall is high from the last transfer until the final sorted record leaves
// reset is synchronous and empties the chain; rsp_stall holds the chain still
module record_merge_sort_by_name #(
   parameter int MAX_RECORDS = 64,
   parameter int NAME_BYTES  = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rmsbn_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rmsbn_pkg::rsp_type rsp_data
);

   localparam int SEQ_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   // bytes beyond NAME_BYTES, counted from the top of the key, are cleared on load
   localparam logic [rmsbn_pkg::KEY_BITS-1:0] NAME_MASK =
      ~({rmsbn_pkg::KEY_BITS{1'b1}} >> (8 * NAME_BYTES));

   rmsbn_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     settle_ff, settle_in;
   logic                 ovf_ff, ovf_in;
   logic                 ins_valid_ff, ins_valid_in;
   rmsbn_pkg::rec_type   ins_rec_ff, ins_rec_in;
   logic [SEQ_W-1:0]     ins_seq_ff, ins_seq_in;

   logic req_accept, rsp_accept, store, full, final_out, shift;

   // chain links: forward path for insertion, held values for the drain shift
   logic               fwd_valid [MAX_RECORDS];
   rmsbn_pkg::rec_type fwd_rec   [MAX_RECORDS];
   logic [SEQ_W-1:0]   fwd_seq   [MAX_RECORDS];
   logic               held_valid [MAX_RECORDS];
   rmsbn_pkg::rec_type held_rec   [MAX_RECORDS];
   logic [SEQ_W-1:0]   held_seq   [MAX_RECORDS];

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign full       = (count_ff == CNT_W'(MAX_RECORDS));
   assign store      = req_accept && !full;
   assign final_out  = (count_ff == CNT_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmsbn_pkg::ST_LOAD: begin
            if (req_accept && req_data.last) state_in = rmsbn_pkg::ST_SETTLE;
         end
         rmsbn_pkg::ST_SETTLE: begin
            if (settle_ff == CNT_W'(MAX_RECORDS)) state_in = rmsbn_pkg::ST_DRAIN;
         end
         rmsbn_pkg::ST_DRAIN: begin
            if (rsp_accept && final_out) state_in = rmsbn_pkg::ST_LOAD;
         end
         default: state_in = rmsbn_pkg::ST_LOAD;
      endcase
   end

   // handshake outputs per state
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rmsbn_pkg::ST_LOAD:   req_stall = 1'b0;
         rmsbn_pkg::ST_SETTLE: req_stall = 1'b1;
         rmsbn_pkg::ST_DRAIN:  rsp_valid = 1'b1;
         default:              req_stall = 1'b1;
      endcase
   end

   assign shift = rsp_accept;

   // counters, overflow flag and the insertion register in front of cell 0
   always_comb begin
      count_in = count_ff;
      if (store) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rsp_accept) begin
         count_in = count_ff - CNT_W'(1);
      end

      ovf_in = ovf_ff;
      if (req_accept && full) begin
         ovf_in = 1'b1;
      end else if (rsp_accept && final_out) begin
         ovf_in = 1'b0;
      end

      settle_in = (state_ff == rmsbn_pkg::ST_SETTLE) ? settle_ff + CNT_W'(1) : '0;

      ins_valid_in = store;
      ins_rec_in.name = {req_data.name_head, req_data.name_middle, req_data.name_tail}
                        & NAME_MASK;
      ins_rec_in.blood_group = req_data.blood_group;
      ins_rec_in.available   = req_data.available;
      // arrival number, used only to keep equal names in load order
      ins_seq_in = count_ff[SEQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmsbn_pkg::ST_LOAD;
         count_ff     <= '0;
         settle_ff    <= '0;
         ovf_ff       <= 1'b0;
         ins_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         settle_ff    <= settle_in;
         ovf_ff       <= ovf_in;
         ins_valid_ff <= ins_valid_in;
      end
      ins_rec_ff <= ins_rec_in;
      ins_seq_ff <= ins_seq_in;
   end

   assign fwd_valid[0] = ins_valid_ff;
   assign fwd_rec[0]   = ins_rec_ff;
   assign fwd_seq[0]   = ins_seq_ff;

   // chain of cells: cell 0 always holds the smallest record
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      if (i < MAX_RECORDS - 1) begin : g_mid
         rmsbn_cell #(.SEQ_W(SEQ_W)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .in_valid    (fwd_valid[i]),
            .in_rec      (fwd_rec[i]),
            .in_seq      (fwd_seq[i]),
            .out_valid   (fwd_valid[i+1]),
            .out_rec     (fwd_rec[i+1]),
            .out_seq     (fwd_seq[i+1]),
            .right_valid (held_valid[i+1]),
            .right_rec   (held_rec[i+1]),
            .right_seq   (held_seq[i+1]),
            .held_valid  (held_valid[i]),
            .held_rec    (held_rec[i]),
            .held_seq    (held_seq[i])
         );
      end else begin : g_end
         // end of the chain: nothing is pushed out, empty slot shifts in
         rmsbn_cell #(.SEQ_W(SEQ_W)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .in_valid    (fwd_valid[i]),
            .in_rec      (fwd_rec[i]),
            .in_seq      (fwd_seq[i]),
            .out_valid   (),
            .out_rec     (),
            .out_seq     (),
            .right_valid (1'b0),
            .right_rec   ('0),
            .right_seq   ('0),
            .held_valid  (held_valid[i]),
            .held_rec    (held_rec[i]),
            .held_seq    (held_seq[i])
         );
      end
   end

   // response taken straight from cell 0; the chain only shifts on a transfer
   always_comb begin
      rsp_data.out_name_head   = held_rec[0].name[159:96];
      rsp_data.out_name_middle = held_rec[0].name[95:32];
      rsp_data.out_name_tail   = held_rec[0].name[31:0];
      rsp_data.out_blood_group = held_rec[0].blood_group;
      rsp_data.out_available   = held_rec[0].available;
      rsp_data.out_last        = final_out && held_valid[0];
      rsp_data.overflowed      = ovf_ff;
   end

endmodule

>>> src/rmsbn_checker.sv
// port-level checks of the record sorter and their binding
`include "record_merge_sort_by_name_assert.svh"

module rmsbn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_data_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rmsbn_pkg::rsp_type rsp_data
);

   // no record is taken in while sorted records are offered
   `RMSBN_ASSERT_NOW(a_no_load_in_drain, rsp_valid, req_stall)

   // the set-closing record blocks further loads at once
   `RMSBN_ASSERT_NEXT(a_stall_after_last, req_valid && !req_stall && req_data_last, req_stall)

   // the final sorted record ends the run
   `RMSBN_ASSERT_NEXT(a_run_ends, rsp_valid && !rsp_stall && rsp_data.out_last, !rsp_valid)

   // a held response stays put
   `RMSBN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind record_merge_sort_by_name rmsbn_checker u_rmsbn_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_data_last (req_data.last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_data      (rsp_data)
);
